// ===== sv/scbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class buffer pool: shared package
// Constants, operation and status codes, register map and the structs that
// pass between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package scbp_pkg;

	localparam int NUM_CLASSES = 16;
	localparam int STACK_DEPTH = 64;
	localparam int ADDR_WIDTH  = 32;

	localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam int BB_W    = 21;              // block_bytes
	localparam int BLK_W   = 5;               // min_blocks / max_blocks
	localparam int LEN_W   = BB_W + BLK_W;    // rounded length
	localparam int BCNT_W  = 33;              // exact block count
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 5;

	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DATA_W-1:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ADDR_WIDTH) - 64'd1);

	localparam logic [BB_W-1:0]   RST_BLOCK_BYTES     = 21'd16384;
	localparam logic [BLK_W-1:0]  RST_MIN_BLOCKS      = 5'd1;
	localparam logic [BLK_W-1:0]  RST_MAX_BLOCKS      = 5'd10;
	localparam logic [DATA_W-1:0] RST_MAX_ALLOC_BYTES = 32'd2097152;
	localparam logic [DATA_W-1:0] RST_MAX_CACHE_BYTES = 32'd2097152;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_RESET = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_OOM     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_BLOCK_BYTES     = 3'd0,
		REG_MIN_BLOCKS      = 3'd1,
		REG_MAX_BLOCKS      = 3'd2,
		REG_MAX_ALLOC_BYTES = 3'd3,
		REG_MAX_CACHE_BYTES = 3'd4,
		REG_ARENA_BYTES     = 3'd5,
		REG_ARENA_PRESENT   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_ROUND,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_POP
	} back_state_t;

	typedef struct packed {
		logic [BB_W-1:0]   block_bytes;
		logic [BLK_W-1:0]  min_blocks;
		logic [BLK_W-1:0]  max_blocks;
		logic [DATA_W-1:0] max_alloc_bytes;
		logic [DATA_W-1:0] max_cache_bytes;
		logic [DATA_W-1:0] arena_bytes;
		logic              arena_present;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic              ok;     // size maps to a class
		logic [CLS_W-1:0]  cls;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] addr;
	} cmd_t;

endpackage

// ===== sv/scbp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class buffer pool: block divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scbp_div
	import scbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [BB_W-1:0]   divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient,
	output logic              rem_nz
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] quo_q;
	logic [BB_W-1:0]   rem_q;
	logic [BB_W:0]     trial;
	logic [BB_W:0]     diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DATA_W-2:0], ge};
			rem_q <= ge ? diff[BB_W-1:0] : trial[BB_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_nz   = rem_q != '0;

endmodule

// ===== sv/scbp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class buffer pool: front end
// Accepts a transaction, rounds the byte count to blocks and picks the class.
// ----------------------------------------------------------------------------
module scbp_front
	import scbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [DATA_W-1:0] request_bytes,
	input  logic [DATA_W-1:0] buffer_addr,
	output logic              push,
	input  logic              full,
	output cmd_t              cmd
);

	front_state_t      state_q, state_d;
	cmd_t              cmd_q;
	logic [BCNT_W-1:0] blocks_q;
	logic              in_fire;
	logic              needs_div;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic              div_rem_nz;
	op_t               op;
	logic [BLK_W-1:0]  blk;
	logic [BLK_W-1:0]  blk_off;
	logic              cls_ok;

	assign op        = op_t'(operation);
	assign in_fire   = in_valid && in_ready;
	assign needs_div = (op == OP_ALLOC || op == OP_FREE) && cfg.block_bytes != '0;

	scbp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (request_bytes),
		.divisor  (cfg.block_bytes),
		.done     (div_done),
		.quotient (div_quo),
		.rem_nz   (div_rem_nz)
	);

	// Class check on the exact block count
	assign blk     = blocks_q[BLK_W-1:0];
	assign blk_off = blk - cfg.min_blocks;
	assign cls_ok  = blocks_q[BCNT_W-1:BLK_W] == '0 && blk >= cfg.min_blocks &&
		blk <= cfg.max_blocks && int'(blk_off) < NUM_CLASSES;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (in_fire) state_d = needs_div ? F_DIV : F_PUSH;
			end
			F_DIV: begin
				if (div_done) state_d = F_ROUND;
			end
			F_ROUND: state_d = F_PUSH;
			F_PUSH: begin
				if (!full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == F_IDLE;
		div_start = in_fire && needs_div;
		push      = state_q == F_PUSH && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q.op   <= op;
			cmd_q.ok   <= 1'b0;
			cmd_q.cls  <= '0;
			cmd_q.len  <= '0;
			cmd_q.addr <= buffer_addr & ADDR_MASK;
		end else if (state_q == F_ROUND) begin
			cmd_q.ok  <= cls_ok;
			cmd_q.cls <= CLS_W'(blk_off);
			cmd_q.len <= LEN_W'(blk) * LEN_W'(cfg.block_bytes);
		end
		if (div_done) begin
			blocks_q <= BCNT_W'(div_quo) + BCNT_W'(div_rem_nz);
		end
	end

	assign cmd = cmd_q;

endmodule

// ===== sv/scbp_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class buffer pool: command queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module scbp_cmdq
	import scbp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_q] <= push_data;
	end

	assign pop_data = entries_q[rd_q];
	assign full     = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;

endmodule

// ===== sv/scbp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class buffer pool: back end
// Executes commands on the class stacks, bump pointer and usage count.
// ----------------------------------------------------------------------------
module scbp_back
	import scbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_empty,
	output logic              q_pop,
	input  cmd_t              q_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [DATA_W-1:0] granted_addr,
	output logic [DATA_W-1:0] granted_bytes
);

	back_state_t       state_q, state_d;
	cmd_t              ex_q;
	logic [CNT_W-1:0]  counts_q [NUM_CLASSES];
	logic [DATA_W-1:0] bump_q;
	logic [DATA_W-1:0] alloc_q;
	logic [DATA_W-1:0] stack_mem [MEM_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] gaddr_q;
	logic [DATA_W-1:0] glen_q;

	logic [CNT_W-1:0]  cnt;
	logic [MEM_AW-1:0] base;
	logic [DATA_W:0]   bump_sum;
	logic [DATA_W:0]   alloc_sum;
	logic [DATA_W-1:0] alloc_up;
	logic [DATA_W-1:0] alloc_down;
	logic              oom;
	logic              out_free;

	logic              pop_hit;
	logic              grant_fresh;
	logic              discard;
	logic              push_mem;
	logic              clear_pool;
	status_t           res_status;
	logic [DATA_W-1:0] res_gaddr;
	logic [DATA_W-1:0] res_glen;

	logic              rd_en;
	logic              commit;
	logic              pop_done;

	assign cnt        = counts_q[ex_q.cls];
	assign base       = MEM_AW'(ex_q.cls) * MEM_AW'(STACK_DEPTH);
	assign bump_sum   = {1'b0, bump_q} + (DATA_W + 1)'(ex_q.len);
	assign oom        = !cfg.arena_present || bump_sum >= {1'b0, cfg.arena_bytes};
	assign alloc_sum  = {1'b0, alloc_q} + (DATA_W + 1)'(ex_q.len);
	assign alloc_up   = alloc_sum[DATA_W] ? '1 : alloc_sum[DATA_W-1:0];
	assign alloc_down = (alloc_q < DATA_W'(ex_q.len)) ? '0 : alloc_q - DATA_W'(ex_q.len);
	assign out_free   = !out_valid_q || out_ready;

	// Decide what the current command does
	always_comb begin
		pop_hit     = 1'b0;
		grant_fresh = 1'b0;
		discard     = 1'b0;
		push_mem    = 1'b0;
		clear_pool  = 1'b0;
		res_status  = ST_OK;
		res_gaddr   = '0;
		res_glen    = '0;
		unique case (ex_q.op)
			OP_ALLOC: begin
				if (!ex_q.ok) begin
					res_status = ST_INVALID;
				end else if (cnt != '0) begin
					pop_hit = 1'b1;
				end else if (alloc_q >= cfg.max_alloc_bytes) begin
					res_status = ST_FULL;
				end else if (oom) begin
					res_status = ST_OOM;
				end else begin
					grant_fresh = 1'b1;
					res_gaddr   = bump_q & ADDR_MASK;
					res_glen    = DATA_W'(ex_q.len);
				end
			end
			OP_FREE: begin
				if (!ex_q.ok) begin
					res_status = ST_INVALID;
				end else if (alloc_q >= cfg.max_cache_bytes ||
					cnt >= CNT_W'(STACK_DEPTH)) begin
					discard = 1'b1;
				end else begin
					push_mem = 1'b1;
				end
			end
			OP_RESET: clear_pool = 1'b1;
			default:  res_status = ST_INVALID;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) state_d = B_EXEC;
			end
			B_EXEC: begin
				if (pop_hit) state_d = B_POP;
				else if (out_free) state_d = B_IDLE;
			end
			B_POP: begin
				if (out_free) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = state_q == B_IDLE && !q_empty;
		rd_en    = state_q == B_EXEC && pop_hit;
		commit   = state_q == B_EXEC && !pop_hit && out_free;
		pop_done = state_q == B_POP && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			bump_q      <= '0;
			alloc_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) counts_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (commit && clear_pool) begin
				for (int i = 0; i < NUM_CLASSES; i++) counts_q[i] <= '0;
			end else if (rd_en) begin
				counts_q[ex_q.cls] <= cnt - 1'b1;
			end else if (commit && push_mem) begin
				counts_q[ex_q.cls] <= cnt + 1'b1;
			end
			if (commit && grant_fresh) bump_q <= bump_sum[DATA_W-1:0];
			if (commit) begin
				if (grant_fresh) alloc_q <= alloc_up;
				else if (discard) alloc_q <= alloc_down;
				else if (clear_pool) alloc_q <= '0;
			end
			if (commit || pop_done) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) ex_q <= q_data;
		if (commit && push_mem) stack_mem[base + MEM_AW'(cnt)] <= ex_q.addr;
		if (rd_en) rd_data_q <= stack_mem[base + MEM_AW'(cnt - 1'b1)];
		if (pop_done) begin
			status_q <= ST_OK;
			gaddr_q  <= rd_data_q;
			glen_q   <= DATA_W'(ex_q.len);
		end else if (commit) begin
			status_q <= res_status;
			gaddr_q  <= res_gaddr;
			glen_q   <= res_glen;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_addr  = gaddr_q;
	assign granted_bytes = glen_q;

endmodule

// ===== sv/size_class_buffer_pool_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class buffer pool core
// Allocate takes a buffer from its class stack or bumps the arena pointer;
// free keeps or discards the buffer; pool reset empties stacks and usage.
// Allocate and free pass through the bit-serial block divider in the front
// end; pool reset, the unused code and any request while block_bytes is zero
// skip it. An allocate that pops a class stack adds a stack read state in the
// back end. A new request is taken only once the front end has queued the
// last one, so the divider, or a full queue, sets the allocate and free rate.
// Reset: arst_n clears registers to defaults, class counts, bump pointer and
// usage at once; the stack memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_core
	import scbp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [DATA_W-1:0]  request_bytes,
	input  logic [DATA_W-1:0]  buffer_addr,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [DATA_W-1:0]  granted_addr,
	output logic [DATA_W-1:0]  granted_bytes
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_empty;
	cmd_t     front_cmd;
	cmd_t     q_head;

	// ------------------------------------------------------------------
	// Configuration registers: write on the access phase of a transaction
	// ------------------------------------------------------------------
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_bytes     <= RST_BLOCK_BYTES;
			cfg_q.min_blocks      <= RST_MIN_BLOCKS;
			cfg_q.max_blocks      <= RST_MAX_BLOCKS;
			cfg_q.max_alloc_bytes <= RST_MAX_ALLOC_BYTES;
			cfg_q.max_cache_bytes <= RST_MAX_CACHE_BYTES;
			cfg_q.arena_bytes     <= '0;
			cfg_q.arena_present   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BLOCK_BYTES:     cfg_q.block_bytes     <= pwdata[BB_W-1:0];
				REG_MIN_BLOCKS:      cfg_q.min_blocks      <= pwdata[BLK_W-1:0];
				REG_MAX_BLOCKS:      cfg_q.max_blocks      <= pwdata[BLK_W-1:0];
				REG_MAX_ALLOC_BYTES: cfg_q.max_alloc_bytes <= pwdata;
				REG_MAX_CACHE_BYTES: cfg_q.max_cache_bytes <= pwdata;
				REG_ARENA_BYTES:     cfg_q.arena_bytes     <= pwdata;
				REG_ARENA_PRESENT:   cfg_q.arena_present   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back: zero-extend each field, unmapped addresses read zero
	always_comb begin
		unique case (reg_idx)
			REG_BLOCK_BYTES:     prdata = DATA_W'(cfg_q.block_bytes);
			REG_MIN_BLOCKS:      prdata = DATA_W'(cfg_q.min_blocks);
			REG_MAX_BLOCKS:      prdata = DATA_W'(cfg_q.max_blocks);
			REG_MAX_ALLOC_BYTES: prdata = cfg_q.max_alloc_bytes;
			REG_MAX_CACHE_BYTES: prdata = cfg_q.max_cache_bytes;
			REG_ARENA_BYTES:     prdata = cfg_q.arena_bytes;
			REG_ARENA_PRESENT:   prdata = DATA_W'(cfg_q.arena_present);
			default:             prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Front end: accept, round to blocks, classify
	// ------------------------------------------------------------------
	scbp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.request_bytes (request_bytes),
		.buffer_addr   (buffer_addr),
		.push          (q_push),
		.full          (q_full),
		.cmd           (front_cmd)
	);

	// ------------------------------------------------------------------
	// Command queue: lets the divider start on the next transaction while
	// the back end waits for the result register to drain
	// ------------------------------------------------------------------
	scbp_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_head),
		.empty     (q_empty)
	);

	// ------------------------------------------------------------------
	// Back end: stacks, bump pointer, usage count and result register
	// ------------------------------------------------------------------
	scbp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_data        (q_head),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_addr  (granted_addr),
		.granted_bytes (granted_bytes)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue read while empty");

	a_fail_grants_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> granted_addr == '0 && granted_bytes == '0)
		else $error("failed transaction carries a grant");

	a_free_has_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && granted_bytes == '0 |-> granted_addr == '0)
		else $error("address granted without a length");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class buffer pool core: self-checking testbench
// Drives allocate, free, pool reset and unknown-operation transactions through
// the request channel and predicts every result from an independent model of
// the class stacks, bump pointer and usage counter. Several register settings
// and idle/stall patterns are exercised, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import scbp_pkg::*;

	localparam int LIMIT = 1_000_000;   // cycles before the watchdog gives up

	// One expected result transaction.
	typedef struct {
		status_t           st;
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] nbytes;
	} grant_t;

	// A buffer handed out by the pool and not yet given back.
	typedef struct {
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] nbytes;
	} held_buf_t;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks pool state and queues the expected grants in order.
	// ------------------------------------------------------------------------
	class pool_scoreboard;
		longint unsigned block_bytes, min_blocks, max_blocks;
		longint unsigned max_alloc_bytes, max_cache_bytes, arena_bytes;
		bit arena_present;
		logic [DATA_W-1:0] stack_mem [MEM_DEPTH];
		int unsigned fill [NUM_CLASSES];
		longint unsigned bump, usage;
		grant_t pending [$];
		int errors, n_requests, n_checked, n_kept, n_dropped, n_overflow;
		int status_seen [4];

		function void clear();
			block_bytes     = RST_BLOCK_BYTES;
			min_blocks      = RST_MIN_BLOCKS;
			max_blocks      = RST_MAX_BLOCKS;
			max_alloc_bytes = RST_MAX_ALLOC_BYTES;
			max_cache_bytes = RST_MAX_CACHE_BYTES;
			arena_bytes     = 0;
			arena_present   = 1'b0;
			foreach (fill[i]) fill[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			bump  = 0;
			usage = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
			case (idx)
			REG_BLOCK_BYTES:     block_bytes     = val[BB_W-1:0];
			REG_MIN_BLOCKS:      min_blocks      = val[BLK_W-1:0];
			REG_MAX_BLOCKS:      max_blocks      = val[BLK_W-1:0];
			REG_MAX_ALLOC_BYTES: max_alloc_bytes = val;
			REG_MAX_CACHE_BYTES: max_cache_bytes = val;
			REG_ARENA_BYTES:     arena_bytes     = val;
			REG_ARENA_PRESENT:   arena_present   = val[0];
			default: ;
			endcase
		endfunction

		// Round up to whole blocks and map the block count to a class.
		function bit map_size(input logic [DATA_W-1:0] nbytes, output int unsigned cls,
			output longint unsigned len);
			longint unsigned blocks;
			cls = 0;
			len = 0;
			if (block_bytes == 0) return 1'b0;
			blocks = ({32'd0, nbytes} + block_bytes - 1) / block_bytes;
			if (blocks < min_blocks || blocks > max_blocks) return 1'b0;
			if (blocks - min_blocks >= NUM_CLASSES) return 1'b0;
			cls = 32'(blocks - min_blocks);
			len = blocks * block_bytes;
			return 1'b1;
		endfunction

		function grant_t note_request(op_t op, logic [DATA_W-1:0] nbytes,
			logic [DATA_W-1:0] addr);
			grant_t g;
			int unsigned cls;
			longint unsigned len;
			g.st = ST_OK;
			g.addr = '0;
			g.nbytes = '0;
			case (op)
			OP_ALLOC: begin
				if (!map_size(nbytes, cls, len)) begin
					g.st = ST_INVALID;
				end else if (fill[cls] > 0) begin
					fill[cls]--;
					g.addr = stack_mem[cls * STACK_DEPTH + fill[cls]];
					g.nbytes = len[31:0];
				end else if (usage >= max_alloc_bytes) begin
					g.st = ST_FULL;
				end else if (!arena_present || bump + len >= arena_bytes) begin
					g.st = ST_OOM;
				end else begin
					g.addr = bump[31:0] & ADDR_MASK;
					bump += len;
					usage += len;
					if (usage > 64'hFFFF_FFFF) usage = 64'hFFFF_FFFF;
					g.nbytes = len[31:0];
				end
			end
			OP_FREE: begin
				if (!map_size(nbytes, cls, len)) begin
					g.st = ST_INVALID;
				end else if (usage >= max_cache_bytes || fill[cls] >= STACK_DEPTH) begin
					// drop the buffer; usage floors at zero
					if (fill[cls] >= STACK_DEPTH) n_overflow++;
					n_dropped++;
					usage = (usage < len) ? 0 : usage - len;
				end else begin
					stack_mem[cls * STACK_DEPTH + fill[cls]] = addr & ADDR_MASK;
					fill[cls]++;
					n_kept++;
				end
			end
			OP_RESET: begin
				foreach (fill[i]) fill[i] = 0;
				usage = 0;
			end
			default: g.st = ST_INVALID;
			endcase
			n_requests++;
			pending.push_back(g);
			return g;
		endfunction

		function void check_result(logic [1:0] st, logic [DATA_W-1:0] addr,
			logic [DATA_W-1:0] nbytes);
			grant_t g;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: status %0d addr %h bytes %h",
					st, addr, nbytes);
				errors++;
				return;
			end
			g = pending.pop_front();
			n_checked++;
			status_seen[g.st]++;
			if (st !== g.st) begin
				$error("status mismatch: expected %0d, got %0d", g.st, st);
				errors++;
			end
			if (addr !== g.addr) begin
				$error("granted_addr mismatch: expected %h, got %h", g.addr, addr);
				errors++;
			end
			if (nbytes !== g.nbytes) begin
				$error("granted_bytes mismatch: expected %h, got %h", g.nbytes, nbytes);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals; every input starts at a known value.
	// ------------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         operation = '0;
	logic [DATA_W-1:0]  request_bytes = '0;
	logic [DATA_W-1:0]  buffer_addr = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [DATA_W-1:0]  granted_addr;
	logic [DATA_W-1:0]  granted_bytes;

	pool_scoreboard sb;
	held_buf_t      held [$];        // buffers currently out, for well-formed frees
	int             tx_idle_pct = 0;  // chance per cycle that the sender idles
	int             rx_stall_pct = 0; // chance per cycle that the receiver stalls
	int             hold_left = 0;    // cycles of forced receiver hold-off left

	size_class_buffer_pool_core uut (.*);

	always #5 clk = ~clk;

	// Receiver: decide ready at each falling edge. A pending hold-off wins over
	// the random stall pattern and is counted down here, one cycle at a time.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// Sample result transactions at the rising edge and check them in order.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, granted_addr, granted_bytes);
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// APB write: setup cycle, then access cycle; the register takes the value
	// at the edge where penable and pready are both high.
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write every register. Buffers out under the old sizes are forgotten,
	// since their byte counts no longer map to the same classes.
	task automatic set_pool_config(logic [DATA_W-1:0] bb, logic [DATA_W-1:0] mn,
		logic [DATA_W-1:0] mx, logic [DATA_W-1:0] alloc_lim, logic [DATA_W-1:0] cache_lim,
		logic [DATA_W-1:0] arena, logic [DATA_W-1:0] present);
		write_reg(REG_BLOCK_BYTES, bb);
		write_reg(REG_MIN_BLOCKS, mn);
		write_reg(REG_MAX_BLOCKS, mx);
		write_reg(REG_MAX_ALLOC_BYTES, alloc_lim);
		write_reg(REG_MAX_CACHE_BYTES, cache_lim);
		write_reg(REG_ARENA_BYTES, arena);
		write_reg(REG_ARENA_PRESENT, present);
		held.delete();
	endtask

	// Offer one request transaction, with random idle cycles ahead of it, and
	// hold it until the block takes it. Record successful grants as held.
	task automatic send_item(op_t op, logic [DATA_W-1:0] nbytes, logic [DATA_W-1:0] addr);
		grant_t    g;
		held_buf_t b;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		request_bytes <= nbytes;
		buffer_addr   <= addr;
		do @(posedge clk); while (!in_ready);
		g = sb.note_request(op, nbytes, addr);
		if (op == OP_ALLOC && g.st == ST_OK) begin
			b.addr   = g.addr;
			b.nbytes = nbytes;
			held.push_back(b);
		end
	endtask

	// Drop valid and wait until every expected result is back, then let the
	// pipeline settle before anything touches the registers.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Byte count in a legal class, when the settings allow one.
	function automatic logic [DATA_W-1:0] valid_bytes();
		longint unsigned bb, blocks;
		bb = sb.block_bytes;
		if (bb == 0 || sb.min_blocks > sb.max_blocks) return $urandom;
		blocks = $urandom_range(32'(sb.min_blocks), 32'(sb.max_blocks));
		return DATA_W'((blocks - 1) * bb + $urandom_range(1, 32'(bb)));
	endfunction

	// Byte count that may fall outside the legal classes.
	function automatic logic [DATA_W-1:0] wild_bytes();
		if ($urandom_range(0, 1)) return $urandom;
		return $urandom_range(0, DATA_W'(sb.block_bytes * (sb.max_blocks + 1)));
	endfunction

	// One random request. Frees mostly give back buffers that are really out;
	// whatever share is left after allocate and free goes to pool reset and
	// the unused operation code.
	task automatic send_random(int alloc_pct, int free_pct);
		int        r, k;
		held_buf_t b;
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			send_item(OP_ALLOC, ($urandom_range(0, 99) < 85) ? valid_bytes() : wild_bytes(),
				$urandom);
		end else if (r < alloc_pct + free_pct) begin
			k = $urandom_range(0, 99);
			if (held.size() > 0 && k < 70) begin
				r = $urandom_range(0, held.size() - 1);
				b = held[r];
				held.delete(r);
				send_item(OP_FREE, b.nbytes, b.addr);
			end else begin
				send_item(OP_FREE, (k < 90) ? valid_bytes() : wild_bytes(), $urandom);
			end
		end else if ($urandom_range(0, 1)) begin
			send_item(OP_RESET, $urandom, $urandom);
		end else begin
			send_item(OP_NONE, $urandom, $urandom);
		end
	endtask

	task automatic run_phase(int n, int tx_pct, int rx_pct, int alloc_pct, int free_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (n) send_random(alloc_pct, free_pct);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		sb.clear();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: 16-byte blocks, all sixteen classes, a 1 KiB arena.
		set_pool_config(16, 1, 16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1024, 1);
		send_item(OP_ALLOC, 0, 0);                    // zero blocks: below min
		send_item(OP_ALLOC, 1, 0);                    // first bump from offset zero
		send_item(OP_ALLOC, 256, 0);                  // largest class
		send_item(OP_ALLOC, 257, 0);                  // one block too many
		send_item(OP_ALLOC, 32'hFFFF_FFFF, 0);        // ceiling must not wrap
		send_item(OP_FREE, 16, 32'hFFFF_FFFF);        // keep, top address bits set
		send_item(OP_ALLOC, 16, 0);                   // pop the kept buffer
		send_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_ALLOC, 256, 0);
		send_item(OP_ALLOC, 256, 0);
		send_item(OP_ALLOC, 256, 0);                  // arena bound reached
		send_item(OP_ALLOC, 200, 0);                  // still fits below the end
		send_item(OP_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// Directed: zero block size rejects allocate and free alike.
		write_reg(REG_BLOCK_BYTES, 0);
		send_item(OP_ALLOC, 5, 0);
		send_item(OP_FREE, 5, 32'h1234);
		drain();

		// Directed: 1 MiB block, single class, zero usage limits.
		set_pool_config(1048576, 16, 16, 0, 0, 32'hFFFF_FFFF, 1);
		send_item(OP_ALLOC, 32'h0100_0000, 0);        // pool full at zero limit
		send_item(OP_FREE, 32'h0100_0000, 32'h123);   // dropped, usage floors at zero
		send_item(OP_ALLOC, 1, 0);                    // below min_blocks
		drain();

		// Directed: arena absent, then present again.
		write_reg(REG_MAX_ALLOC_BYTES, 32'hFFFF_FFFF);
		write_reg(REG_ARENA_PRESENT, 0);
		send_item(OP_ALLOC, 32'h0100_0000, 0);        // out of memory
		drain();
		write_reg(REG_ARENA_PRESENT, 1);
		send_item(OP_ALLOC, 32'h0100_0000, 0);
		send_item(OP_ALLOC, 32'h00FF_FFFF, 0);
		drain();

		// Random, no idling: small blocks, generous limits.
		set_pool_config(16, 1, 16, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			DATA_W'(sb.bump + (1 << 20)), 1);
		run_phase(150, 0, 0, 55, 40);
		drain();

		// Random, sender mostly idle: tight limits so pool-full, discard and
		// out-of-memory answers all show up.
		begin
			logic [DATA_W-1:0] bb, mn;
			bb = $urandom_range(1, 4096);
			mn = $urandom_range(1, 4);
			set_pool_config(bb, mn, mn + $urandom_range(0, 12),
				bb * $urandom_range(8, 40), bb * $urandom_range(4, 30),
				DATA_W'(sb.bump + bb * $urandom_range(100, 300)), 1);
		end
		run_phase(150, 87, 0, 50, 45);
		drain();

		// Random, receiver mostly stalling: one class, mostly frees, so the
		// class stack overflows and frees turn into discards.
		set_pool_config(1, 5, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			DATA_W'(sb.bump + 5000), 1);
		run_phase(200, 0, 87, 20, 80);
		drain();

		// Random, both sides idling: megabyte blocks over the full arena.
		set_pool_config(1048576, 1, 16, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF, 1);
		run_phase(150, 36, 36, 50, 45);
		drain();

		// Back-pressure: hold the receiver off while the sender keeps offering,
		// so the block fills and stalls its input; then pause the sender until
		// everything is back, and carry on with both sides idling.
		set_pool_config(16, 2, 9, 2000, 1000, DATA_W'(sb.bump + 3000), 1);
		hold_left = 400;
		run_phase(60, 0, 0, 50, 45);
		drain();
		run_phase(40, 87, 87, 50, 45);
		drain();

		// Degenerate settings: min above max, empty absent arena.
		set_pool_config(1, 16, 1, 0, 0, 0, 0);
		run_phase(20, 36, 0, 50, 45);
		drain();

		$display("tb: %0d requests, %0d results checked; ok %0d, invalid %0d, full %0d, oom %0d",
			sb.n_requests, sb.n_checked, sb.status_seen[ST_OK], sb.status_seen[ST_INVALID],
			sb.status_seen[ST_FULL], sb.status_seen[ST_OOM]);
		$display("tb: frees kept %0d, discarded %0d (%0d on a full class stack)",
			sb.n_kept, sb.n_dropped, sb.n_overflow);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
sv/scbp_pkg.sv
sv/scbp_div.sv
sv/scbp_front.sv
sv/scbp_cmdq.sv
sv/scbp_back.sv
sv/size_class_buffer_pool_core.sv
bench/tb_top.sv
